[rtl/bce_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bce_pkg
// shared types and constants of the bezier curve evaluator
// ----------------------------------------------------------------------------
package bce_pkg;

	// fixed field widths of the channels
	localparam int OPCODE_W = 1;
	localparam int INDEX_W  = 3;
	localparam int COORD_W  = 32;
	localparam int PARAM_W  = 17;
	localparam int TAN_W    = 36;
	localparam int COUNT_W  = 4;

	// opcodes of an input word
	localparam logic [OPCODE_W-1:0] OP_LOAD = 1'b0;
	localparam logic [OPCODE_W-1:0] OP_EVAL = 1'b1;

	// register index, taken from paddr[2]
	localparam logic REG_POINT_COUNT = 1'b0;

	// reset value of point_count
	localparam logic [COUNT_W-1:0] POINT_COUNT_RST = 4'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ADD,
		ST_SKIP,
		ST_FIN
	} bce_state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic store_wr;
		logic load;
		logic mul;
		logic write;
		logic shift;
		logic tan_diff;
		logic tan_zero;
		logic capture;
	} bce_cmd_t;

endpackage
`default_nettype wire

[rtl/bce_in_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bce_in_if
// input channel: load or evaluate words
// ----------------------------------------------------------------------------
interface bce_in_if;
	logic                                valid;
	logic                                ready;
	logic        [bce_pkg::OPCODE_W-1:0] opcode;
	logic        [bce_pkg::INDEX_W-1:0]  point_index;
	logic signed [bce_pkg::COORD_W-1:0]  coord_x;
	logic signed [bce_pkg::COORD_W-1:0]  coord_y;
	logic signed [bce_pkg::COORD_W-1:0]  coord_z;
	logic        [bce_pkg::PARAM_W-1:0]  param_t;

	modport source (
		output valid, opcode, point_index, coord_x, coord_y, coord_z, param_t,
		input  ready
	);
	modport sink (
		input  valid, opcode, point_index, coord_x, coord_y, coord_z, param_t,
		output ready
	);
endinterface
`default_nettype wire

[rtl/bce_out_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bce_out_if
// result channel: curve point and tangent
// ----------------------------------------------------------------------------
interface bce_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [bce_pkg::COORD_W-1:0] point_x;
	logic signed [bce_pkg::COORD_W-1:0] point_y;
	logic signed [bce_pkg::COORD_W-1:0] point_z;
	logic signed [bce_pkg::TAN_W-1:0]   tangent_x;
	logic signed [bce_pkg::TAN_W-1:0]   tangent_y;
	logic signed [bce_pkg::TAN_W-1:0]   tangent_z;

	modport source (
		output valid, point_x, point_y, point_z, tangent_x, tangent_y, tangent_z,
		input  ready
	);
	modport sink (
		input  valid, point_x, point_y, point_z, tangent_x, tangent_y, tangent_z,
		output ready
	);
endinterface
`default_nettype wire

[rtl/bce_lane.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bce_lane
// one coordinate work row with its shared interpolation unit
// ----------------------------------------------------------------------------
module bce_lane #(
	parameter int MAX_POINTS = 8,
	parameter int FRAC_BITS  = 16,
	parameter int W          = 32,
	parameter int IW         = 3
) (
	input  wire logic                     clk,
	input  wire bce_pkg::bce_cmd_t        cmd,
	input  wire logic                     diff,
	input  wire logic [IW-1:0]            tail,
	input  wire logic [IW-1:0]            fcount,
	input  wire logic [FRAC_BITS:0]       t,
	input  wire logic signed [31:0]       init [MAX_POINTS],
	output logic signed [W-1:0]           head
);
	localparam int PW = W + FRAC_BITS + 3;

	logic signed [W-1:0]       work_q [MAX_POINTS];
	logic signed [W-1:0]       a;
	logic signed [W-1:0]       b;
	logic signed [W-1:0]       res;
	logic signed [W:0]         delta;
	logic        [FRAC_BITS:0] factor;
	logic signed [FRAC_BITS+1:0] factor_s;
	logic signed [PW-1:0]      prod_q;
	logic signed [PW-1:0]      sum;

	assign a        = work_q[0];
	assign b        = work_q[1 % MAX_POINTS];
	assign delta    = (W+1)'(b) - (W+1)'(a);
	assign factor   = diff ? (FRAC_BITS+1)'(fcount) : t;
	assign factor_s = $signed({1'b0, factor});

	// a + floor((b - a) * t / one) equals the floored convex combination
	assign sum = PW'(a) + (prod_q >>> FRAC_BITS);
	assign res = diff ? W'(prod_q) : W'(sum);

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_q <= delta * factor_s;
		end
		if (cmd.load) begin
			for (int k = 0; k < MAX_POINTS; k++) begin
				work_q[k] <= W'(init[k]);
			end
		end else if (cmd.write || cmd.shift) begin
			// rotate left, new value enters at the tail of the level
			for (int k = 0; k < MAX_POINTS; k++) begin
				if (cmd.write && tail == IW'(k)) begin
					work_q[k] <= res;
				end else if (k < MAX_POINTS - 1) begin
					work_q[k] <= work_q[(k + 1) % MAX_POINTS];
				end
			end
		end
	end

	assign head = work_q[0];

endmodule
`default_nettype wire

[rtl/bce_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bce_datapath
// control point stores, six work lanes and the result register
// ----------------------------------------------------------------------------
module bce_datapath #(
	parameter int MAX_POINTS = 8,
	parameter int FRAC_BITS  = 16,
	parameter int IW         = 3,
	parameter int TW         = 36
) (
	input  wire logic                               clk,
	input  wire bce_pkg::bce_cmd_t                  cmd,
	input  wire logic [IW-1:0]                      level,
	input  wire logic [IW-1:0]                      fcount,
	input  wire logic [bce_pkg::INDEX_W-1:0]        point_index,
	input  wire logic signed [bce_pkg::COORD_W-1:0] coord_x,
	input  wire logic signed [bce_pkg::COORD_W-1:0] coord_y,
	input  wire logic signed [bce_pkg::COORD_W-1:0] coord_z,
	input  wire logic [bce_pkg::PARAM_W-1:0]        param_t,
	output logic signed [bce_pkg::COORD_W-1:0]      point_x,
	output logic signed [bce_pkg::COORD_W-1:0]      point_y,
	output logic signed [bce_pkg::COORD_W-1:0]      point_z,
	output logic signed [bce_pkg::TAN_W-1:0]        tangent_x,
	output logic signed [bce_pkg::TAN_W-1:0]        tangent_y,
	output logic signed [bce_pkg::TAN_W-1:0]        tangent_z
);
	localparam int TAN_W = bce_pkg::TAN_W;
	localparam logic [31:0] ONE_FX = 32'(1) << FRAC_BITS;

	logic signed [31:0] store_x_q [MAX_POINTS];
	logic signed [31:0] store_y_q [MAX_POINTS];
	logic signed [31:0] store_z_q [MAX_POINTS];
	logic [FRAC_BITS:0] t_q;
	logic [FRAC_BITS:0] t_clamped;

	logic signed [31:0]   head_px, head_py, head_pz;
	logic signed [TW-1:0] head_tx, head_ty, head_tz;

	assign t_clamped = (32'(param_t) > ONE_FX) ? (FRAC_BITS+1)'(ONE_FX)
		: (FRAC_BITS+1)'(param_t);

	always_ff @(posedge clk) begin
		if (cmd.store_wr) begin
			// slots at or beyond the depth are never matched
			for (int k = 0; k < MAX_POINTS; k++) begin
				if (32'(point_index) == k) begin
					store_x_q[k] <= coord_x;
					store_y_q[k] <= coord_y;
					store_z_q[k] <= coord_z;
				end
			end
		end
		if (cmd.load) begin
			t_q <= t_clamped;
		end
	end

	bce_lane #(.MAX_POINTS(MAX_POINTS), .FRAC_BITS(FRAC_BITS), .W(32), .IW(IW)) u_lane_px (
		.clk(clk), .cmd(cmd), .diff(1'b0), .tail(level), .fcount(fcount), .t(t_q),
		.init(store_x_q), .head(head_px)
	);
	bce_lane #(.MAX_POINTS(MAX_POINTS), .FRAC_BITS(FRAC_BITS), .W(32), .IW(IW)) u_lane_py (
		.clk(clk), .cmd(cmd), .diff(1'b0), .tail(level), .fcount(fcount), .t(t_q),
		.init(store_y_q), .head(head_py)
	);
	bce_lane #(.MAX_POINTS(MAX_POINTS), .FRAC_BITS(FRAC_BITS), .W(32), .IW(IW)) u_lane_pz (
		.clk(clk), .cmd(cmd), .diff(1'b0), .tail(level), .fcount(fcount), .t(t_q),
		.init(store_z_q), .head(head_pz)
	);
	bce_lane #(.MAX_POINTS(MAX_POINTS), .FRAC_BITS(FRAC_BITS), .W(TW), .IW(IW)) u_lane_tx (
		.clk(clk), .cmd(cmd), .diff(cmd.tan_diff), .tail(level), .fcount(fcount),
		.t(t_q), .init(store_x_q), .head(head_tx)
	);
	bce_lane #(.MAX_POINTS(MAX_POINTS), .FRAC_BITS(FRAC_BITS), .W(TW), .IW(IW)) u_lane_ty (
		.clk(clk), .cmd(cmd), .diff(cmd.tan_diff), .tail(level), .fcount(fcount),
		.t(t_q), .init(store_y_q), .head(head_ty)
	);
	bce_lane #(.MAX_POINTS(MAX_POINTS), .FRAC_BITS(FRAC_BITS), .W(TW), .IW(IW)) u_lane_tz (
		.clk(clk), .cmd(cmd), .diff(cmd.tan_diff), .tail(level), .fcount(fcount),
		.t(t_q), .init(store_z_q), .head(head_tz)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			point_x   <= head_px;
			point_y   <= head_py;
			point_z   <= head_pz;
			tangent_x <= cmd.tan_zero ? '0 : TAN_W'(head_tx);
			tangent_y <= cmd.tan_zero ? '0 : TAN_W'(head_ty);
			tangent_z <= cmd.tan_zero ? '0 : TAN_W'(head_tz);
		end
	end

endmodule
`default_nettype wire

[rtl/bce_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bce_ctrl
// sequencer over de casteljau levels and steps, result handshake
// ----------------------------------------------------------------------------
module bce_ctrl #(
	parameter int MAX_POINTS = 8,
	parameter int IW         = 3
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          item_valid,
	input  wire logic [bce_pkg::OPCODE_W-1:0]  item_opcode,
	output logic                               item_ready,
	input  wire logic                          rsp_ready,
	output logic                               rsp_valid,
	input  wire logic [bce_pkg::COUNT_W-1:0]   point_count,
	output bce_pkg::bce_cmd_t                  cmd,
	output logic [IW-1:0]                      level,
	output logic [IW-1:0]                      fcount
);
	bce_pkg::bce_state_t state_q, state_d;
	logic [IW-1:0] level_q;
	logic [IW-1:0] step_q;
	logic [IW-1:0] nm1_q;
	logic [IW-1:0] nm1_new;
	logic          out_valid_q;
	logic          accept;

	// clamp the point count into 1..MAX_POINTS, kept as count minus one
	always_comb begin
		if (point_count == '0) begin
			nm1_new = '0;
		end else if (32'(point_count) > MAX_POINTS) begin
			nm1_new = IW'(MAX_POINTS - 1);
		end else begin
			nm1_new = IW'(point_count - bce_pkg::COUNT_W'(1));
		end
	end

	assign accept = item_valid && item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bce_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q     <= '0;
			step_q      <= '0;
			nm1_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				nm1_q   <= nm1_new;
				level_q <= nm1_new;
				step_q  <= '0;
			end else if (cmd.write) begin
				step_q <= step_q + IW'(1);
			end else if (cmd.shift) begin
				level_q <= level_q - IW'(1);
				step_q  <= '0;
			end
			if (cmd.capture) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.tan_diff = (level_q == nm1_q);
		item_ready   = 1'b0;
		case (state_q)
			bce_pkg::ST_IDLE: begin
				item_ready = 1'b1;
				if (accept) begin
					if (item_opcode == bce_pkg::OP_LOAD) begin
						cmd.store_wr = 1'b1;
					end else begin
						cmd.load = 1'b1;
						state_d  = (nm1_new == '0) ? bce_pkg::ST_FIN : bce_pkg::ST_MUL;
					end
				end
			end
			bce_pkg::ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = bce_pkg::ST_ADD;
			end
			bce_pkg::ST_ADD: begin
				cmd.write = 1'b1;
				state_d   = (step_q == level_q - IW'(1)) ? bce_pkg::ST_SKIP : bce_pkg::ST_MUL;
			end
			bce_pkg::ST_SKIP: begin
				cmd.shift = 1'b1;
				state_d   = (level_q == IW'(1)) ? bce_pkg::ST_FIN : bce_pkg::ST_MUL;
			end
			bce_pkg::ST_FIN: begin
				cmd.tan_zero = (nm1_q == '0);
				if (!out_valid_q || rsp_ready) begin
					cmd.capture = 1'b1;
					state_d     = bce_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bce_pkg::ST_IDLE;
			end
		endcase
	end

	assign rsp_valid = out_valid_q;
	assign level     = level_q;
	assign fcount    = nm1_q;

	// a step index stays inside its level while multiplying
	a_step_in_level: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bce_pkg::ST_MUL |-> step_q < level_q)
		else $error("step index beyond level");

	// the reduction never runs at level zero
	a_level_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bce_pkg::ST_MUL || state_q == bce_pkg::ST_ADD ||
		 state_q == bce_pkg::ST_SKIP) |-> level_q != '0)
		else $error("reduction at level zero");

	// a finished result waits while the output word is still held
	a_fin_waits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bce_pkg::ST_FIN && out_valid_q && !rsp_ready
		|=> state_q == bce_pkg::ST_FIN)
		else $error("result overwrote a pending word");

	// a capture always presents a word
	a_capture_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> out_valid_q)
		else $error("capture without valid");

endmodule
`default_nettype wire

[rtl/bezier_curve_eval_with_tangent.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bezier_curve_eval_with_tangent
// de casteljau bezier point and tangent evaluator, fixed point, apb config
// ----------------------------------------------------------------------------
// loads: a load word is stored from idle, and loads are accepted back to back
// evaluate: an evaluate with n points walks n - 1 levels, then raises result valid
//   (level L costs L multiply/add step pairs plus one rotate step)
// evaluates run one at a time on the shared multiplier of each lane; no new word is taken until the result is captured
// reset: arst_n clears the sequencer and sets point_count to 1; point stores
//   are not cleared and must be loaded before they are read
// ----------------------------------------------------------------------------
module bezier_curve_eval_with_tangent #(
	parameter int MAX_POINTS = 8,
	parameter int FRAC_BITS  = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	bce_in_if.sink           item,
	bce_out_if.source        result,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);
	// index width of the work rows, at least one bit
	localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	// tangent work width: a point difference times up to MAX_POINTS - 1
	localparam int TW = 33 + $clog2(MAX_POINTS);

	bce_pkg::bce_cmd_t cmd;
	logic [IW-1:0]     level;
	logic [IW-1:0]     fcount;
	logic [bce_pkg::COUNT_W-1:0] point_count_q;
	logic              cfg_wr;

	// apb register file: one register, point_count, at byte address 0
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= bce_pkg::POINT_COUNT_RST;
		end else if (cfg_wr && paddr[2] == bce_pkg::REG_POINT_COUNT) begin
			point_count_q <= pwdata[bce_pkg::COUNT_W-1:0];
		end
	end

	// read back, unmapped addresses read zero
	assign prdata = (paddr[2] == bce_pkg::REG_POINT_COUNT)
		? {{(32 - bce_pkg::COUNT_W){1'b0}}, point_count_q} : '0;

	// sequencer: walks levels from n-1 down to 1, each step shifts the work rows
	// and writes the new value at the row tail, and a final shift closes the level
	bce_ctrl #(.MAX_POINTS(MAX_POINTS), .IW(IW)) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item.valid),
		.item_opcode (item.opcode),
		.item_ready  (item.ready),
		.rsp_ready   (result.ready),
		.rsp_valid   (result.valid),
		.point_count (point_count_q),
		.cmd         (cmd),
		.level       (level),
		.fcount      (fcount)
	);

	// datapath: the tangent rows first form scaled differences on the top
	// level, then interpolate in lock step with the point rows
	bce_datapath #(
		.MAX_POINTS (MAX_POINTS),
		.FRAC_BITS  (FRAC_BITS),
		.IW         (IW),
		.TW         (TW)
	) u_datapath (
		.clk         (clk),
		.cmd         (cmd),
		.level       (level),
		.fcount      (fcount),
		.point_index (item.point_index),
		.coord_x     (item.coord_x),
		.coord_y     (item.coord_y),
		.coord_z     (item.coord_z),
		.param_t     (item.param_t),
		.point_x     (result.point_x),
		.point_y     (result.point_y),
		.point_z     (result.point_z),
		.tangent_x   (result.tangent_x),
		.tangent_y   (result.tangent_y),
		.tangent_z   (result.tangent_z)
	);

endmodule
`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the bezier point and tangent evaluator
// ----------------------------------------------------------------------------
// control points and evaluate words are pushed through the input channel while
// a local de casteljau predictor tracks the point stores and point_count; every
// evaluate queues one predicted curve sample which the result monitor compares
// field by field. directed words cover the extremes and corner cases, then four
// random phases run with different sender idling and receiver stalling
// ----------------------------------------------------------------------------
module tb_top;
	import bce_pkg::*;

	localparam int     MAX_PTS       = 8;
	localparam int     FRAC_Q        = 16;
	localparam longint ONE_Q         = 64'sd1 << FRAC_Q;
	localparam int     SETTLE_CYCLES = MAX_PTS * MAX_PTS + 8;
	localparam int     CYCLE_LIMIT   = 500000;
	localparam int     PHASE_WORDS   = 200;
	localparam int     WORDS_PER_CFG = 50;

	// register index that decodes to nothing
	localparam logic REG_NONE = ~REG_POINT_COUNT;

	typedef logic signed [COORD_W-1:0] coord_set_t [MAX_PTS];
	typedef longint lane_t [MAX_PTS];

	// one word of the input channel
	typedef struct {
		logic        [OPCODE_W-1:0] opcode;
		logic        [INDEX_W-1:0]  slot;
		logic signed [COORD_W-1:0]  x;
		logic signed [COORD_W-1:0]  y;
		logic signed [COORD_W-1:0]  z;
		logic        [PARAM_W-1:0]  t;
	} curve_word_t;

	// one curve sample: point and tangent at t
	typedef struct {
		logic signed [COORD_W-1:0] px;
		logic signed [COORD_W-1:0] py;
		logic signed [COORD_W-1:0] pz;
		logic signed [TAN_W-1:0]   tx;
		logic signed [TAN_W-1:0]   ty;
		logic signed [TAN_W-1:0]   tz;
	} curve_sample_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	bce_in_if  item_ch ();
	bce_out_if result_ch ();

	bezier_curve_eval_with_tangent dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// predictor state: shadow point stores and the point_count register
	coord_set_t    shadow_x;
	coord_set_t    shadow_y;
	coord_set_t    shadow_z;
	logic [MAX_PTS-1:0] slot_loaded;
	logic [COUNT_W-1:0] shadow_count;

	// curve samples still owed by the block, oldest first
	curve_sample_t pending_samples [$];

	int mismatch_count;
	int samples_seen;
	int cycle_count;
	int send_idle_pct;
	int recv_stall_pct;

	// ------------------------------------------------------------------------
	// clock, cycle limit
	// ------------------------------------------------------------------------
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// hard stop if the block hangs or drops a word
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d samples owed", cycle_count,
				pending_samples.size());
			$display("status: fail");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------------

	// repeated linear interpolation of cnt values down to one, floor shift
	function automatic longint casteljau_reduce(input lane_t v, input int cnt,
		input longint t);
		lane_t w;
		int    lvl;
		int    i;
		w = v;
		for (lvl = cnt - 1; lvl > 0; lvl--)
			for (i = 0; i < lvl; i++)
				w[i] = (w[i] * (ONE_Q - t) + w[i + 1] * t) >>> FRAC_Q;
		return w[0];
	endfunction

	// point and tangent of one coordinate axis
	function automatic void sample_axis(input coord_set_t store, input int n,
		input longint t, output logic signed [COORD_W-1:0] pt,
		output logic signed [TAN_W-1:0] tan);
		lane_t  lane;
		longint acc;
		int     i;
		for (i = 0; i < MAX_PTS; i++)
			lane[i] = longint'(store[i]);
		acc = casteljau_reduce(lane, n, t);
		pt = acc[COORD_W-1:0];
		tan = '0;
		// derivative curve: (n-1) times the forward differences
		if (n > 1) begin
			for (i = 0; i < n - 1; i++)
				lane[i] = (longint'(store[i + 1]) - longint'(store[i])) * (n - 1);
			acc = casteljau_reduce(lane, n - 1, t);
			tan = acc[TAN_W-1:0];
		end
	endfunction

	// update the shadow stores or queue the sample for an accepted word
	task automatic advance_curve_state(input curve_word_t w);
		curve_sample_t s;
		int            n;
		longint        t;
		if (w.opcode == OP_LOAD) begin
			shadow_x[w.slot] = w.x;
			shadow_y[w.slot] = w.y;
			shadow_z[w.slot] = w.z;
			slot_loaded[w.slot] = 1'b1;
		end else begin
			// count of zero acts as one, above the store size as the store size
			n = int'(shadow_count);
			if (n < 1)
				n = 1;
			if (n > MAX_PTS)
				n = MAX_PTS;
			// t above one is clamped to one
			t = longint'(w.t);
			if (t > ONE_Q)
				t = ONE_Q;
			sample_axis(shadow_x, n, t, s.px, s.tx);
			sample_axis(shadow_y, n, t, s.py, s.ty);
			sample_axis(shadow_z, n, t, s.pz, s.tz);
			pending_samples.insert(pending_samples.size(), s);
		end
	endtask

	// ------------------------------------------------------------------------
	// result monitor and receiver stalls
	// ------------------------------------------------------------------------
	task automatic report_mismatch(input string msg);
		mismatch_count++;
		$display("mismatch: %s", msg);
	endtask

	task automatic check_field(input string field, input longint got,
		input longint want);
		if (got != want)
			report_mismatch($sformatf("sample %0d %s got %0d want %0d",
				samples_seen, field, got, want));
	endtask

	task automatic check_sample(input curve_sample_t got);
		curve_sample_t want;
		if (pending_samples.size() == 0) begin
			report_mismatch($sformatf("sample %0d arrived with none owed", samples_seen));
		end else begin
			want = pending_samples.pop_front();
			check_field("point_x",   got.px, want.px);
			check_field("point_y",   got.py, want.py);
			check_field("point_z",   got.pz, want.pz);
			check_field("tangent_x", got.tx, want.tx);
			check_field("tangent_y", got.ty, want.ty);
			check_field("tangent_z", got.tz, want.tz);
		end
		samples_seen++;
	endtask

	// values sampled here are the ones before this edge's updates
	always @(posedge clk) begin
		curve_sample_t got;
		if (arst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			got.px = result_ch.point_x;
			got.py = result_ch.point_y;
			got.pz = result_ch.point_z;
			got.tx = result_ch.tangent_x;
			got.ty = result_ch.tangent_y;
			got.tz = result_ch.tangent_z;
			check_sample(got);
		end
		result_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// ------------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------------

	// drive one word, with random idle cycles before it, until accepted
	task automatic send_word(input curve_word_t w);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid       <= 1'b1;
		item_ch.opcode      <= w.opcode;
		item_ch.point_index <= w.slot;
		item_ch.coord_x     <= w.x;
		item_ch.coord_y     <= w.y;
		item_ch.coord_z     <= w.z;
		item_ch.param_t     <= w.t;
		@(posedge clk);
		while (item_ch.ready !== 1'b1)
			@(posedge clk);
		advance_curve_state(w);
	endtask

	task automatic load_point(input int slot, input logic signed [COORD_W-1:0] x,
		input logic signed [COORD_W-1:0] y, input logic signed [COORD_W-1:0] z);
		curve_word_t w;
		w.opcode = OP_LOAD;
		w.slot   = slot[INDEX_W-1:0];
		w.x      = x;
		w.y      = y;
		w.z      = z;
		w.t      = PARAM_W'($urandom);
		send_word(w);
	endtask

	task automatic eval_at(input logic [PARAM_W-1:0] t);
		curve_word_t w;
		w.opcode = OP_EVAL;
		w.slot   = INDEX_W'($urandom);
		w.x      = $urandom;
		w.y      = $urandom;
		w.z      = $urandom;
		w.t      = t;
		send_word(w);
	endtask

	// stop sending, wait for every owed sample, then let the sequencer settle
	task automatic wait_curve_idle();
		item_ch.valid <= 1'b0;
		while (pending_samples.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// apb write: setup cycle, then access until pready
	task automatic write_reg(input logic reg_idx, input logic [COUNT_W-1:0] value);
		logic [31:0] data;
		data = {28'($urandom), value};
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (pready !== 1'b1)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (reg_idx == REG_POINT_COUNT)
			shadow_count = data[COUNT_W-1:0];
	endtask

	// half of the time edges of the Q16.16 range and small values, else anything
	function automatic logic signed [COORD_W-1:0] pick_coord();
		case ($urandom_range(0, 9))
			0: return 32'sh7fff_ffff;
			1: return 32'sh8000_0000;
			2: return '0;
			3: return -32'sd1;
			4: return COORD_W'($signed($urandom_range(0, 2 ** 21)) - 2 ** 20);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [PARAM_W-1:0] pick_param();
		case ($urandom_range(0, 11))
			0: return '0;
			1: return PARAM_W'(ONE_Q);
			2: return PARAM_W'($urandom_range(ONE_Q + 1, 2 ** PARAM_W - 1));
			3: return PARAM_W'(1);
			4: return PARAM_W'(ONE_Q - 1);
			default: return PARAM_W'($urandom_range(0, ONE_Q));
		endcase
	endfunction

	// counts in use, with the clamped values now and then
	function automatic logic [COUNT_W-1:0] pick_count();
		case ($urandom_range(0, 9))
			0: return COUNT_W'(1);
			1: return COUNT_W'(MAX_PTS);
			2: return '0;
			3: return COUNT_W'($urandom_range(MAX_PTS + 1, 15));
			default: return COUNT_W'($urandom_range(2, MAX_PTS - 1));
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// fill every slot with range extremes, single point curve at reset count
	task automatic test_single_point();
		load_point(0, 32'sh7fff_ffff, 32'sh8000_0000, 32'sd0);
		load_point(1, 32'sh8000_0000, 32'sh7fff_ffff, -32'sd1);
		load_point(2, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff);
		load_point(3, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000);
		load_point(4, 32'sd0, -32'sd1, 32'sh0001_0000);
		load_point(5, -32'sd1, 32'sd0, -32'sh0001_0000);
		load_point(6, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000);
		load_point(7, 32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff);
		// point_count is 1 out of reset: point is slot 0, tangent zero
		eval_at('0);
		eval_at(PARAM_W'(ONE_Q));
		wait_curve_idle();
	endtask

	// full degree curve at the ends, the middle and beyond one
	task automatic test_full_degree();
		write_reg(REG_POINT_COUNT, COUNT_W'(MAX_PTS));
		eval_at('0);
		eval_at(PARAM_W'(ONE_Q));
		eval_at(PARAM_W'(ONE_Q / 2));
		eval_at(PARAM_W'(ONE_Q + 1));
		eval_at({PARAM_W{1'b1}});
		wait_curve_idle();
		// line between two extreme points
		write_reg(REG_POINT_COUNT, COUNT_W'(2));
		eval_at(PARAM_W'(ONE_Q / 4));
		wait_curve_idle();
	endtask

	// out of range counts clamp, writes to a missing register are dropped
	task automatic test_count_clamps();
		write_reg(REG_POINT_COUNT, '0);
		eval_at(PARAM_W'(ONE_Q / 3));
		wait_curve_idle();
		write_reg(REG_POINT_COUNT, {COUNT_W{1'b1}});
		eval_at(PARAM_W'(ONE_Q - 1));
		wait_curve_idle();
		write_reg(REG_POINT_COUNT, COUNT_W'(3));
		write_reg(REG_NONE, COUNT_W'(7));
		eval_at(PARAM_W'(1));
		// reload a slot in use and evaluate straight after
		load_point(1, 32'sd0, 32'sh7fff_ffff, 32'sh8000_0000);
		load_point(2, -32'sd1, 32'sd1, 32'sd0);
		eval_at(PARAM_W'(ONE_Q / 2 + 1));
		wait_curve_idle();
	endtask

	// random loads and evaluates; every few dozen words the sender stops
	// until all owed samples are back and point_count changes
	task automatic test_random_traffic(input int idle_pct, input int stall_pct,
		input int words);
		curve_word_t w;
		int          k;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		for (k = 0; k < words; k++) begin
			if (k % WORDS_PER_CFG == 0) begin
				wait_curve_idle();
				write_reg(REG_POINT_COUNT, pick_count());
			end
			w.opcode = ($urandom_range(0, 99) < 45) ? OP_LOAD : OP_EVAL;
			w.slot   = INDEX_W'($urandom);
			w.x      = pick_coord();
			w.y      = pick_coord();
			w.z      = pick_coord();
			w.t      = pick_param();
			send_word(w);
		end
		wait_curve_idle();
	endtask

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	initial begin
		int i;
		arst_n              = 1'b0;
		psel                = 1'b0;
		penable             = 1'b0;
		pwrite              = 1'b0;
		paddr               = '0;
		pwdata              = '0;
		item_ch.valid       = 1'b0;
		item_ch.opcode      = OP_LOAD;
		item_ch.point_index = '0;
		item_ch.coord_x     = '0;
		item_ch.coord_y     = '0;
		item_ch.coord_z     = '0;
		item_ch.param_t     = '0;
		result_ch.ready     = 1'b0;
		mismatch_count      = 0;
		samples_seen        = 0;
		cycle_count         = 0;
		send_idle_pct       = 0;
		recv_stall_pct      = 0;
		slot_loaded         = '0;
		shadow_count        = POINT_COUNT_RST;
		for (i = 0; i < MAX_PTS; i++) begin
			shadow_x[i] = '0;
			shadow_y[i] = '0;
			shadow_z[i] = '0;
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_single_point();
		test_full_degree();
		test_count_clamps();
		test_random_traffic(0, 0, PHASE_WORDS);
		test_random_traffic(60, 0, PHASE_WORDS);
		test_random_traffic(0, 60, PHASE_WORDS);
		test_random_traffic(36, 36, PHASE_WORDS);

		if (mismatch_count == 0 && pending_samples.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
